### hw/rtl/xs128_pkg.sv
// ============================================================================
// xs128_pkg
// Shared types and constants of the xorshift128 random generator.
// ============================================================================
`default_nettype none

package xs128_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned NUM_WORDS = 4;

    localparam logic [1:0] OP_RESEED = 2'd0;
    localparam logic [1:0] OP_RAW    = 2'd1;
    localparam logic [1:0] OP_RANGE  = 2'd2;
    localparam logic [1:0] OP_PROB   = 2'd3;

    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam int unsigned       SEED_SHIFT   = 30;
    localparam int unsigned       SHIFT_A      = 11;
    localparam int unsigned       SHIFT_B      = 19;
    localparam int unsigned       SHIFT_C      = 8;
    localparam logic [WORD_W-1:0] PERCENT_SPAN = 32'd100;
    localparam logic [PCT_W-1:0]  PERCENT_MAX  = 7'd100;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/xs128_req_if.sv
// ============================================================================
// xs128_req_if
// Request channel: one word holds an operation and its operands.
// ============================================================================
`default_nettype none

interface xs128_req_if;

    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
    logic [6:0]        percent;

    modport source (
        output valid, operation, range_min, range_max, percent,
        input  ready
    );

    modport sink (
        input  valid, operation, range_min, range_max, percent,
        output ready
    );

endinterface

`default_nettype wire

### hw/rtl/xs128_rsp_if.sv
// ============================================================================
// xs128_rsp_if
// Response channel: one word holds the result of one operation.
// ============================================================================
`default_nettype none

interface xs128_rsp_if;

    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               decision;
    logic               error;

    modport source (
        output valid, value, decision, error,
        input  ready
    );

    modport sink (
        input  valid, value, decision, error,
        output ready
    );

endinterface

`default_nettype wire

### hw/rtl/xs128_divider.sv
// ============================================================================
// xs128_divider
// Radix-2 restoring divider that returns the remainder.
// ============================================================================
`default_nettype none

module xs128_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  xs128_pkg::div_req_t    div_req,
    output xs128_pkg::div_rsp_t    div_rsp
);

    logic [4:0]  count_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] divisor_reg;

    logic [32:0] trial;
    logic [33:0] diff;
    logic [31:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[31]};
        diff  = {1'b0, trial} - {2'b00, divisor_reg};
        if (diff[33])
        begin
            rem_next = trial[31:0];
        end
        else
        begin
            rem_next = diff[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (div_req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 5'd1;
                if (count_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= div_req.dividend;
            divisor_reg <= div_req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[30:0], 1'b0};
        end
    end

    assign div_rsp.done      = done_reg;
    assign div_rsp.remainder = rem_reg;

endmodule

`default_nettype wire

### hw/rtl/xorshift128_random_generator_unit.sv
// ============================================================================
// xorshift128_random_generator_unit
// Xorshift128 generator with reseed, raw, range and probability draws.
// ============================================================================
// Requests arrive on req and each one gives exactly one word on rsp.
// The user must write the seed register through cfg_we and cfg_wdata
// only while idle; the block itself does not enforce this. A reseed
// runs on one 32-bit multiplier, one generator word per cycle, and
// emits its word once all four are written. A raw draw steps the
// generator once, then emits its word. Range and probability draws run
// the draw through a shared radix-2 divider for its remainder, and this
// divider sets the throughput; a range with max <= min skips it.
// The block takes one request at a time; req.ready is high only while
// it is idle, and a new request may be taken while the last word still
// waits on rsp. If the receiver stalls, the finished word holds in the
// output register and the next result waits until it is taken.
// Reset clears the seed register and all four generator words, so an
// unseeded generator draws zero, and drops any word not yet delivered.
// ============================================================================
`default_nettype none

module xorshift128_random_generator_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,
    xs128_req_if.sink         req,
    xs128_rsp_if.source       rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_STEP,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [1:0]         seed_idx_reg;
    logic [31:0]        seed_reg;
    logic [31:0]        mix_reg;
    logic [31:0]        words_reg [xs128_pkg::NUM_WORDS];

    logic [1:0]         op_reg;
    logic signed [31:0] min_reg;
    logic signed [31:0] max_reg;
    logic [6:0]         pct_reg;

    logic [31:0]        res_value_reg;
    logic               res_decision_reg;
    logic               res_error_reg;

    logic               rsp_valid_reg;
    logic [31:0]        rsp_value_reg;
    logic               rsp_decision_reg;
    logic               rsp_error_reg;

    logic [31:0]        seed_mix;
    logic [31:0]        seed_prod;
    logic [31:0]        step_t;
    logic [31:0]        draw;
    logic [32:0]        span;
    logic               span_bad;
    logic [6:0]         pct_clamped;

    xs128_pkg::div_req_t div_req;
    xs128_pkg::div_rsp_t div_rsp;

    xs128_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    always_comb
    begin
        seed_mix  = mix_reg ^ (mix_reg >> xs128_pkg::SEED_SHIFT);
        seed_prod = 32'(seed_mix * xs128_pkg::SEED_MULT) + {30'd0, seed_idx_reg};

        step_t = words_reg[0] ^ (words_reg[0] << xs128_pkg::SHIFT_A);
        draw   = (words_reg[3] ^ (words_reg[3] >> xs128_pkg::SHIFT_B))
               ^ (step_t ^ (step_t >> xs128_pkg::SHIFT_C));

        span     = {max_reg[31], max_reg} - {min_reg[31], min_reg};
        span_bad = span[32] || (span == 33'd0);

        if (pct_reg > xs128_pkg::PERCENT_MAX)
        begin
            pct_clamped = xs128_pkg::PERCENT_MAX;
        end
        else
        begin
            pct_clamped = pct_reg;
        end

        div_req.start    = (state_reg == ST_STEP)
                        && ((op_reg == xs128_pkg::OP_PROB)
                        || ((op_reg == xs128_pkg::OP_RANGE) && !span_bad));
        div_req.dividend = draw;
        if (op_reg == xs128_pkg::OP_RANGE)
        begin
            div_req.divisor = span[31:0];
        end
        else
        begin
            div_req.divisor = xs128_pkg::PERCENT_SPAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_idx_reg  <= '0;
            seed_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < xs128_pkg::NUM_WORDS; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            if (rsp.ready && (state_reg != ST_EMIT))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        seed_idx_reg <= '0;
                        if (req.operation == xs128_pkg::OP_RESEED)
                        begin
                            state_reg <= ST_SEED;
                        end
                        else
                        begin
                            state_reg <= ST_STEP;
                        end
                    end
                end
                ST_SEED:
                begin
                    words_reg[seed_idx_reg] <= seed_prod;
                    seed_idx_reg            <= seed_idx_reg + 2'd1;
                    if (seed_idx_reg == 2'd3)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_STEP:
                begin
                    words_reg[0] <= words_reg[1];
                    words_reg[1] <= words_reg[2];
                    words_reg[2] <= words_reg[3];
                    words_reg[3] <= draw;
                    if (div_req.start)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_reg  <= req.operation;
                    min_reg <= req.range_min;
                    max_reg <= req.range_max;
                    pct_reg <= req.percent;
                    mix_reg <= seed_reg;
                end
            end
            ST_SEED:
            begin
                mix_reg          <= seed_prod;
                res_value_reg    <= '0;
                res_decision_reg <= 1'b0;
                res_error_reg    <= 1'b0;
            end
            ST_STEP:
            begin
                res_decision_reg <= 1'b0;
                if (op_reg == xs128_pkg::OP_RAW)
                begin
                    res_value_reg <= draw;
                    res_error_reg <= 1'b0;
                end
                else if ((op_reg == xs128_pkg::OP_RANGE) && span_bad)
                begin
                    res_value_reg <= min_reg;
                    res_error_reg <= 1'b1;
                end
                else
                begin
                    res_value_reg <= '0;
                    res_error_reg <= 1'b0;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (op_reg == xs128_pkg::OP_RANGE)
                    begin
                        res_value_reg <= min_reg + div_rsp.remainder;
                    end
                    else
                    begin
                        res_decision_reg <= (pct_clamped <= div_rsp.remainder[6:0]);
                    end
                end
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_value_reg    <= res_value_reg;
                    rsp_decision_reg <= res_decision_reg;
                    rsp_error_reg    <= res_error_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready    = (state_reg == ST_IDLE);
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.value    = rsp_value_reg;
    assign rsp.decision = rsp_decision_reg;
    assign rsp.error    = rsp_error_reg;

endmodule

`default_nettype wire

### hw/rtl/xs128_checker.sv
// ============================================================================
// xs128_checker
// Port-level checks of the xorshift128 generator, bound to its top level.
// ============================================================================
`default_nettype none

module xs128_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] rsp_value,
    input wire logic        rsp_decision,
    input wire logic        rsp_error
);

    // The block works on one request at a time.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready
    ) else $error("request accepted while a request is in flight");

    a_rsp_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)
            && $stable(rsp_decision) && $stable(rsp_error))
    ) else $error("stalled response word changed");

    a_error_excl: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_error) |-> !rsp_decision
    ) else $error("error and decision both set");

    a_decision_excl: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_decision) |-> (rsp_value == 32'd0)
    ) else $error("probability word carries a nonzero value");

endmodule

bind xorshift128_random_generator_unit xs128_checker u_xs128_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_value    (rsp.value),
    .rsp_decision (rsp.decision),
    .rsp_error    (rsp.error)
);

`default_nettype wire
